@@ design/terminal_line_editor_top_assert.svh @@
// assertion macros for the terminal line editor
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define TLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define TLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/tle_pkg.sv @@
// shared constants and types for the terminal line editor
`timescale 1ns / 1ps
package tle_pkg;
    localparam int LINE_SIZE_DEF = 16;
    localparam int SLOT          = 16;
    localparam int NPH           = 6;
    localparam logic [2:0] PH_MEM  = 3'd3;
    localparam logic [2:0] PH_LAST = 3'd5;

    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_CSI   = 8'h5B;
    localparam logic [7:0] C_K1    = 8'h31;
    localparam logic [7:0] C_K3    = 8'h33;
    localparam logic [7:0] C_K4    = 8'h34;
    localparam logic [7:0] C_K5    = 8'h35;
    localparam logic [7:0] C_K6    = 8'h36;
    localparam logic [7:0] C_TILDE = 8'h7E;
    localparam logic [7:0] C_UP    = 8'h41;
    localparam logic [7:0] C_DOWN  = 8'h42;
    localparam logic [7:0] C_RIGHT = 8'h43;
    localparam logic [7:0] C_LEFT  = 8'h44;
    localparam logic [7:0] C_DEL   = 8'h7F;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_NUL   = 8'h00;

    typedef enum logic [3:0] {
        K_REG, K_BKSP, K_ENTER, K_HOME, K_DEL, K_END, K_PAGE, K_SWAP, K_RIGHT, K_LEFT, K_NONE
    } t_key;

    typedef enum logic [1:0] {
        M_READ, M_INS, M_CLOSE
    } t_mode;
endpackage

@@ design/terminal_line_editor_top.sv @@
// terminal line editor: escape matcher, line store memory and echo sequencer
//
// input channel: i_in_valid / o_in_stall carry one received byte i_rx_byte.
// output channel: o_out_valid / i_out_stall carry results (o_kind, o_out_byte,
// o_last); o_last marks the final result caused by one input byte, and a byte
// that causes no result gives no transaction.
// one byte is worked at a time: o_in_stall is high from acceptance until all
// of its results are handed to the output register.
// each result that reads the line store needs a memory read, then an emit,
// with write-back when inserting or closing a gap; constant echo bytes are
// emitted directly; the sequencer steps past each of its six phases. the
// longest work for one byte is an arrow swap between two full lines.
// a stalled output holds its transaction and stops further emits; empty
// phases are still stepped past and a pending memory read still happens.
// reset (synchronous, active low) empties both lines, clears cursor, history
// selection and escape matching; the line store is not cleared.
`timescale 1ns / 1ps
`include "terminal_line_editor_top_assert.svh"
module terminal_line_editor_top
    import tle_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    localparam logic [4:0] LS = 5'(LINE_SIZE);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state     r_st;
    logic [7:0] r_mem [2*SLOT];
    logic [7:0] r_rdata;
    logic [4:0] r_blen [2];
    logic [4:0] r_cur, r_len;
    logic       r_ab;
    logic [3:0] r_me;
    logic [1:0] r_md;
    logic [4:0] r_cnt [NPH];
    logic [7:0] r_cb  [NPH];
    logic       r_ck  [NPH];
    logic [2:0] r_ph;
    t_mode      r_mode;
    logic       r_mab;
    logic [3:0] r_idx;
    logic       r_mrd;
    logic [7:0] r_carry;
    logic       r_ov, r_okind, r_olast;
    logic [7:0] r_obyte;

    t_key       key;
    logic [3:0] n_me;
    logic [1:0] n_md;
    logic [4:0] n_cur, n_len, nl;
    logic       n_ab, n_mab, blen_we;
    logic [4:0] n_cnt [NPH];
    logic [7:0] n_cb  [NPH];
    logic       n_ck  [NPH];
    t_mode      n_mode;
    logic [3:0] n_idx;
    logic       accept, free, later_zero, last_emit, n_ov;

    assign accept = i_in_valid && (r_st == S_IDLE);
    assign o_in_stall = (r_st != S_IDLE);
    assign free = !r_ov || !i_out_stall;
    assign n_ov = free ? (r_st == S_RUN && r_cnt[r_ph] != 5'd0 && (r_ph != PH_MEM || r_mrd))
                       : r_ov;

    always_comb begin
        key  = K_REG;
        n_me = 4'd0;
        n_md = 2'd0;
        case (r_md)
            2'd0: begin
                if (i_rx_byte inside {C_BS, C_DEL}) begin
                    key = K_BKSP;
                end else if (i_rx_byte == C_CR) begin
                    key = K_ENTER;
                end else if (i_rx_byte == C_ESC) begin
                    key = K_NONE; n_me = 4'd2; n_md = 2'd1;
                end
            end
            2'd1: begin
                if (i_rx_byte == C_CSI) begin
                    key = K_NONE; n_me = 4'd2; n_md = 2'd2;
                end
            end
            2'd2: begin
                case (i_rx_byte)
                    C_K1: begin key = K_NONE; n_me = 4'd2; n_md = 2'd3; end
                    C_K3: begin key = K_NONE; n_me = 4'd3; n_md = 2'd3; end
                    C_K4: begin key = K_NONE; n_me = 4'd4; n_md = 2'd3; end
                    C_K5: begin key = K_NONE; n_me = 4'd5; n_md = 2'd3; end
                    C_K6: begin key = K_NONE; n_me = 4'd6; n_md = 2'd3; end
                    C_UP, C_DOWN: key = K_SWAP;
                    C_RIGHT: key = K_RIGHT;
                    C_LEFT: key = K_LEFT;
                    default: key = K_REG;
                endcase
            end
            default: begin
                if (i_rx_byte == C_TILDE) begin
                    case (r_me)
                        4'd2: key = K_HOME;
                        4'd3: key = K_DEL;
                        4'd4: key = K_END;
                        default: key = K_PAGE;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        n_cur = r_cur;
        n_len = r_len;
        n_ab  = r_ab;
        n_mab = r_ab;
        blen_we = 1'b0;
        n_mode = M_READ;
        n_idx = 4'd0;
        nl = 5'd0;
        for (int k = 0; k < NPH; k++) begin
            n_cnt[k] = 5'd0;
            n_cb[k]  = C_BS;
            n_ck[k]  = 1'b0;
        end
        case (key)
            K_REG: begin
                if (r_cur < LS) begin
                    nl = (r_len < LS) ? r_len + 5'd1 : LS;
                    n_mode = M_INS;
                    n_idx = r_cur[3:0];
                    n_cnt[PH_MEM] = nl - r_cur;
                    n_cnt[4] = nl - r_cur - 5'd1;
                    n_cur = r_cur + 5'd1;
                    n_len = nl;
                end
            end
            K_BKSP, K_DEL: begin
                if ((key == K_BKSP && r_cur != 5'd0) || (key == K_DEL && r_cur != r_len)) begin
                    if (key == K_BKSP) begin
                        n_cur = r_cur - 5'd1;
                        n_cnt[0] = 5'd1;
                    end
                    n_len = r_len - 5'd1;
                    n_mode = M_CLOSE;
                    n_idx = n_cur[3:0];
                    n_cnt[PH_MEM] = n_len - n_cur;
                    n_cnt[4] = 5'd1;
                    n_cb[4] = C_SP;
                    n_cnt[5] = n_len - n_cur + 5'd1;
                end
            end
            K_ENTER: begin
                n_cnt[PH_MEM] = r_len;
                n_ck[PH_MEM] = 1'b1;
                n_cnt[4] = 5'd1;
                n_cb[4] = C_NUL;
                n_ck[4] = 1'b1;
                if (r_len != 5'd0) begin
                    blen_we = 1'b1;
                    n_ab = !r_ab;
                    n_len = 5'd0;
                    n_cur = 5'd0;
                end
            end
            K_HOME: begin
                n_cnt[0] = r_cur;
                n_cur = 5'd0;
            end
            K_END: begin
                n_idx = r_cur[3:0];
                n_cnt[PH_MEM] = r_len - r_cur;
                n_cur = r_len;
            end
            K_SWAP: begin
                n_cnt[0] = r_cur;
                n_cnt[1] = r_len;
                n_cb[1] = C_SP;
                n_cnt[2] = r_len;
                blen_we = 1'b1;
                n_ab = !r_ab;
                n_mab = !r_ab;
                n_cnt[PH_MEM] = r_blen[!r_ab];
                n_len = r_blen[!r_ab];
                n_cur = r_blen[!r_ab];
            end
            K_RIGHT: begin
                if (r_cur < r_len) begin
                    n_idx = r_cur[3:0];
                    n_cnt[PH_MEM] = 5'd1;
                    n_cur = r_cur + 5'd1;
                end
            end
            K_LEFT: begin
                if (r_cur != 5'd0) begin
                    n_cnt[0] = 5'd1;
                    n_cur = r_cur - 5'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        later_zero = 1'b1;
        for (int k = 0; k < NPH; k++) begin
            if (3'(k) > r_ph && r_cnt[k] != 5'd0) later_zero = 1'b0;
        end
        last_emit = (r_cnt[r_ph] == 5'd1) && later_zero;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_RUN && r_ph == PH_MEM && r_cnt[PH_MEM] != 5'd0) begin
            if (!r_mrd) begin
                r_rdata <= r_mem[{r_mab, (r_mode == M_CLOSE) ? r_idx + 4'd1 : r_idx}];
            end else if (free && r_mode == M_INS) begin
                r_mem[{r_mab, r_idx}] <= r_carry;
            end else if (free && r_mode == M_CLOSE) begin
                r_mem[{r_mab, r_idx}] <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_blen[0] <= 5'd0;
            r_blen[1] <= 5'd0;
            r_cur <= 5'd0;
            r_len <= 5'd0;
            r_ab <= 1'b0;
            r_me <= 4'd0;
            r_md <= 2'd0;
            r_ph <= 3'd0;
            r_mrd <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < NPH; k++) r_cnt[k] <= 5'd0;
        end else begin
            r_ov <= n_ov;
            case (r_st)
                S_IDLE: begin
                    if (accept) begin
                        r_st <= S_RUN;
                        r_me <= n_me;
                        r_md <= n_md;
                        r_cur <= n_cur;
                        r_len <= n_len;
                        r_ab <= n_ab;
                        if (blen_we) r_blen[r_ab] <= r_len;
                        r_mab <= n_mab;
                        r_mode <= n_mode;
                        r_idx <= n_idx;
                        r_carry <= i_rx_byte;
                        r_ph <= 3'd0;
                        r_mrd <= 1'b0;
                        for (int k = 0; k < NPH; k++) begin
                            r_cnt[k] <= n_cnt[k];
                            r_cb[k] <= n_cb[k];
                            r_ck[k] <= n_ck[k];
                        end
                    end
                end
                S_RUN: begin
                    if (r_cnt[r_ph] == 5'd0) begin
                        if (r_ph == PH_LAST) r_st <= S_IDLE;
                        else r_ph <= r_ph + 3'd1;
                    end else if (r_ph == PH_MEM) begin
                        if (!r_mrd) begin
                            r_mrd <= 1'b1;
                        end else if (free) begin
                            r_okind <= r_ck[PH_MEM];
                            r_obyte <= (r_mode == M_INS) ? r_carry : r_rdata;
                            r_olast <= last_emit;
                            r_carry <= r_rdata;
                            r_idx <= r_idx + 4'd1;
                            r_cnt[PH_MEM] <= r_cnt[PH_MEM] - 5'd1;
                            r_mrd <= 1'b0;
                        end
                    end else if (free) begin
                        r_okind <= r_ck[r_ph];
                        r_obyte <= r_cb[r_ph];
                        r_olast <= last_emit;
                        r_cnt[r_ph] <= r_cnt[r_ph] - 5'd1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_okind;
    assign o_out_byte  = r_obyte;
    assign o_last      = r_olast;

    `TLE_ASSERT(a_cur_le_len, r_cur <= r_len, "cursor beyond line end")
    `TLE_ASSERT(a_len_le_max, r_len <= LS, "line longer than line size")
    `TLE_ASSERT_IMP(a_mrd_in_mem, r_mrd, r_ph == PH_MEM, "memory read outside memory phase")
    `TLE_ASSERT_IMP(a_emit_busy, $rose(r_ov), $past(r_st) == S_RUN, "result while idle")
endmodule

@@ test/tb_terminal_line_editor_top.sv @@
// testbench for the terminal line editor: key stimulus, line model and result scoreboard
`timescale 1ns / 1ps
module tb_terminal_line_editor_top;
    import tle_pkg::*;

    localparam int LSZ = LINE_SIZE_DEF;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_echo;

    class editor_scoreboard;
        logic [7:0] lines [0:31];
        logic [4:0] blen [0:1];
        logic [4:0] cur, len;
        logic       act;
        int         mentry, mdepth;
        t_echo      pending [$];
        int         errors;
        t_echo      step_res [$];

        function new();
            foreach (lines[i]) lines[i] = 8'h00;
            blen[0] = 0; blen[1] = 0;
            cur = 0; len = 0; act = 0; mentry = 0; mdepth = 0; errors = 0;
        endfunction

        function automatic logic [7:0] kcode(int e, int p);
            logic [7:0] t [0:11][0:3];
            t[0] = '{C_BS, 0, 0, 0};          t[1] = '{C_CR, 0, 0, 0};
            t[2] = '{C_ESC, C_CSI, C_K1, C_TILDE};
            t[3] = '{C_ESC, C_CSI, C_K3, C_TILDE};
            t[4] = '{C_ESC, C_CSI, C_K4, C_TILDE};
            t[5] = '{C_ESC, C_CSI, C_K5, C_TILDE};
            t[6] = '{C_ESC, C_CSI, C_K6, C_TILDE};
            t[7] = '{C_ESC, C_CSI, C_UP, 0};  t[8] = '{C_ESC, C_CSI, C_DOWN, 0};
            t[9] = '{C_ESC, C_CSI, C_RIGHT, 0}; t[10] = '{C_ESC, C_CSI, C_LEFT, 0};
            t[11] = '{C_DEL, 0, 0, 0};
            return t[e][p];
        endfunction

        function automatic int klen(int e);
            return (e < 2 || e == 11) ? 1 : (e < 7 ? 4 : 3);
        endfunction

        function automatic t_key kkind(int e);
            t_key k [0:11];
            k = '{K_BKSP, K_ENTER, K_HOME, K_DEL, K_END, K_PAGE, K_PAGE,
                  K_SWAP, K_SWAP, K_RIGHT, K_LEFT, K_BKSP};
            return k[e];
        endfunction

        function automatic bit has(logic [7:0] c, int e, int p);
            if (e >= 12 || p >= klen(e)) return 0;
            return c == kcode(e, p);
        endfunction

        function automatic int addr(int i);
            return {act, 4'(i)};
        endfunction

        function void put(logic k, logic [7:0] b);
            t_echo r;
            if (step_res.size() < 64) begin
                r.kind = k; r.data = b; r.last = 0;
                step_res.push_back(r);
            end
        endfunction

        function void backs(int n);
            for (int i = 0; i < n; i++) put(0, C_BS);
        endfunction

        function void close_gap();
            for (int i = cur; i < len; i++) begin
                lines[addr(i)] = lines[addr(i + 1)];
                put(0, lines[addr(i)]);
            end
            put(0, C_SP);
            backs(int'(len) - int'(cur) + 1);
        endfunction

        function void note_input(logic [7:0] c);
            int e, p, n;
            bit found;
            t_key key;
            e = mentry; p = mdepth;
            step_res.delete();
            if (e >= 12) e = 0;
            found = has(c, e, p);
            if (!found) begin
                if (c < kcode(e, p)) begin
                    for (int i = e; i > 0 && !found; i--)
                        if (has(c, i - 1, p)) begin e = i - 1; found = 1; end
                end else begin
                    for (int i = e + 1; i < 12 && !found; i++)
                        if (has(c, i, p)) begin e = i; found = 1; end
                end
            end
            if (found) begin
                p++;
                if (p >= klen(e)) begin
                    key = kkind(e); mentry = 0; mdepth = 0;
                end else begin
                    mentry = e; mdepth = p; key = K_NONE;
                end
            end else begin
                mentry = 0; mdepth = 0; key = K_REG;
            end
            if (cur > len) cur = len;
            case (key)
                K_REG: if (cur < LSZ) begin
                    n = (len < LSZ) ? len + 1 : LSZ;
                    for (int i = n - 1; i > cur; i--) lines[addr(i)] = lines[addr(i - 1)];
                    lines[addr(cur)] = c;
                    cur++;
                    len = 5'(n);
                    for (int i = cur - 1; i < len; i++) put(0, lines[addr(i)]);
                    backs(int'(len) - int'(cur));
                end
                K_BKSP: if (cur != 0) begin
                    len--; cur--;
                    put(0, C_BS);
                    close_gap();
                end
                K_ENTER: begin
                    for (int i = 0; i < len; i++) put(1, lines[addr(i)]);
                    put(1, C_NUL);
                    if (len != 0) begin
                        blen[act] = len; act ^= 1'b1; len = 0; cur = 0;
                    end
                end
                K_HOME: begin backs(cur); cur = 0; end
                K_DEL: if (cur != len) begin len--; close_gap(); end
                K_END: while (cur < len) begin put(0, lines[addr(cur)]); cur++; end
                K_SWAP: begin
                    backs(cur);
                    for (int i = 0; i < len; i++) put(0, C_SP);
                    backs(len);
                    blen[act] = len; act ^= 1'b1;
                    len = blen[act];
                    if (len > LSZ) len = LSZ;
                    for (int i = 0; i < len; i++) put(0, lines[addr(i)]);
                    cur = len;
                end
                K_RIGHT: if (cur < len) begin put(0, lines[addr(cur)]); cur++; end
                K_LEFT: if (cur != 0) begin put(0, C_BS); cur--; end
                default: ;
            endcase
            if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1;
            foreach (step_res[i]) pending.push_back(step_res[i]);
        endfunction

        function void check_result(logic k, logic [7:0] b, logic l);
            t_echo x;
            if (pending.size() == 0) begin
                $error("unexpected transaction kind=%0d byte=%h last=%0d", k, b, l);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (k !== x.kind) begin
                $error("kind expected %0d actual %0d", x.kind, k); errors++;
            end
            if (b !== x.data) begin
                $error("out_byte expected %h actual %h", x.data, b); errors++;
            end
            if (l !== x.last) begin
                $error("last expected %0d actual %0d", x.last, l); errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_in_valid = 0;
    logic [7:0] i_rx_byte = 0;
    logic       i_out_stall = 0;
    logic       o_in_stall, o_out_valid, o_kind, o_last;
    logic [7:0] o_out_byte;

    editor_scoreboard sb = new();
    bit calm = 0;
    bit hold_off = 0;

    terminal_line_editor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_out_byte(o_out_byte), .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_input(i_rx_byte);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_kind, o_out_byte, o_last);
    end

    // receiver stall process
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
                i_out_stall <= 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 16);
                i_out_stall <= 1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_out_stall <= 0;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            i_in_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_seq(logic [7:0] s [$]);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic send_key(int k);
        case (k)
            0: send_byte(C_BS);
            1: send_byte(C_DEL);
            2: send_byte(C_CR);
            3: send_seq('{C_ESC, C_CSI, C_K1, C_TILDE});
            4: send_seq('{C_ESC, C_CSI, C_K3, C_TILDE});
            5: send_seq('{C_ESC, C_CSI, C_K4, C_TILDE});
            6: send_seq('{C_ESC, C_CSI, C_K5, C_TILDE});
            7: send_seq('{C_ESC, C_CSI, C_K6, C_TILDE});
            8: send_seq('{C_ESC, C_CSI, C_UP});
            9: send_seq('{C_ESC, C_CSI, C_DOWN});
            10: send_seq('{C_ESC, C_CSI, C_RIGHT});
            11: send_seq('{C_ESC, C_CSI, C_LEFT});
            12: send_seq('{C_ESC, C_CSI, 8'($urandom_range(0, 255))});
            13: send_seq('{C_ESC, C_ESC});
            14: send_byte(8'($urandom_range(0, 255)));
            default: send_byte(printable());
        endcase
    endtask

    initial begin
        int wait_n;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed
        send_byte(C_BS);
        send_seq('{C_ESC, C_CSI, C_LEFT});
        send_seq('{C_ESC, C_CSI, C_RIGHT});
        send_seq('{C_ESC, C_CSI, C_K3, C_TILDE});
        send_byte(C_CR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_seq('{C_ESC, C_CSI, C_K1, C_TILDE});
        for (int i = 0; i < 17; i++) send_byte(8'(8'h41 + i));
        send_seq('{C_ESC, C_CSI, C_K5, C_TILDE});
        send_seq('{C_ESC, C_CSI, C_K6, C_TILDE});
        send_seq('{C_ESC, C_CSI, C_K4, C_TILDE});
        send_byte(C_DEL);
        send_seq('{C_ESC, C_CSI, 8'h7A});
        send_seq('{C_ESC, C_ESC});
        send_byte(C_CR);
        send_seq('{C_ESC, C_CSI, C_UP});
        send_seq('{C_ESC, C_CSI, C_DOWN});

        // long receiver hold-off while input keeps coming
        hold_off = 1;
        for (int i = 0; i < 12; i++) send_byte(printable());

        for (int i = 0; i < 100; i++) begin
            if (i > 80) calm = 1;
            send_key($urandom_range(0, 30));
        end
        send_byte(C_CR);
        i_in_valid <= 0;

        wait_n = 0;
        while (sb.pending.size() != 0 && wait_n < 20000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
